>>> hdl/jpeg_entropy_bit_reader_unit_assert.svh
// Assertion macros used by the checker module of the bit reader.
`ifndef JPEG_ENTROPY_BIT_READER_UNIT_ASSERT_SVH
`define JPEG_ENTROPY_BIT_READER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JEBR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define JEBR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/jebr_pkg.sv
// Shared types and constants of the JPEG entropy bit reader.
package jebr_pkg;

    typedef enum logic [2:0] {
        KIND_DATA    = 3'd0,
        KIND_END     = 3'd1,
        KIND_READ    = 3'd2,
        KIND_PEEK    = 3'd3,
        KIND_CONSUME = 3'd4,
        KIND_ALIGN   = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_MERGE,
        ST_FINISH
    } t_state;

    localparam logic [1:0] FAULT_NONE     = 2'd0;
    localparam logic [1:0] FAULT_INVALID  = 2'd1;
    localparam logic [1:0] FAULT_OVERFLOW = 2'd2;

    localparam logic [7:0] BYTE_ESCAPE = 8'hFF;
    localparam logic [7:0] BYTE_STUFF  = 8'h00;
    localparam logic [7:0] MARK_NONE   = 8'h00;
    localparam logic [7:0] MARK_EOI    = 8'hD9;

    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 48;

endpackage

>>> hdl/jebr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module jebr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/jpeg_entropy_bit_reader_unit.sv
// JPEG entropy-coded segment bit reader: destuffing, byte FIFO and bit buffer.
//
// Input channel (s_axis): tuser carries the item kind, tdata the raw byte and
// the bit count. Data bytes are destuffed on acceptance and written into a
// byte FIFO RAM; an end item latches the EOI marker. Neither produces a
// result. Read, peek, consume and align produce one result on the
// m_axis channel: bits, starved flag, sticky fault code and latched marker.
//
// A request without refill goes from idle straight to the finish state. A read
// or peek that refills the bit buffer pops bytes from the FIFO RAM one at a
// time, each through a fetch state (read issue) and a merge state (merge of
// the registered read data), up to 3 bytes popped or padded per request.
// The result register then presents the item on m_axis.
//
// Only one item is in work at a time. If the result register still holds an
// untaken result, a finished request waits in place until m_axis_tready; data
// and end items can still be accepted as long as no request is in work.
// Reset (synchronous, active low) empties the FIFO, the bit buffer, the
// marker and the fault; FIFO contents need no clearing.
module jpeg_entropy_bit_reader_unit #(
    parameter int QUEUE_DEPTH = 16,
    parameter int FILL_CAP    = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [7:0] data_byte, [12:8] bit_request, [15:13] zero
    input  logic [jebr_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // [2:0] kind
    input  logic [jebr_pkg::IN_USER_W-1:0]    s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [30:0] bits_value, [31] starved, [33:32] fault_code, [41:34] marker_seen,
    // [47:42] zero
    output logic [jebr_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
    import jebr_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST   = PW'(QUEUE_DEPTH - 1);
    localparam logic [LW-1:0] LEVEL_FULL = LW'(QUEUE_DEPTH);
    localparam logic [4:0]    CAP        = 5'(FILL_CAP);

    t_state          r_state, n_state;
    logic [31:0]     r_buf, n_buf;
    logic [4:0]      r_held, n_held;
    logic            r_pending, n_pending;
    logic [7:0]      r_marker, n_marker;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [LW-1:0]   r_level, n_level;
    logic [1:0]      r_fault, n_fault;
    logic            r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;
    logic [2:0]      r_kind, n_kind;
    logic [4:0]      r_req, n_req;
    logic [4:0]      r_target, n_target;
    logic            r_starve, n_starve;
    logic            r_from_ram, n_from_ram;

    logic            ram_we, ram_re;
    logic [7:0]      ram_wdata, ram_rdata;

    logic [7:0]      in_byte;
    logic [4:0]      in_req;
    logic [2:0]      in_kind;
    logic            in_accept;
    logic [4:0]      w_target;
    logic [2:0]      w_need;
    logic            w_starve;
    logic            w_out_free;
    logic [4:0]      w_held_add;
    logic [31:0]     w_value;
    logic [4:0]      w_new_held;

    assign in_byte    = s_axis_tdata[7:0];
    assign in_req     = s_axis_tdata[12:8];
    assign in_kind    = s_axis_tuser[2:0];
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_accept  = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_held_add = r_held + 5'd8;

    // Fill target and the number of FIFO bytes the fill would need.
    always_comb begin
        w_target = (in_req > CAP) ? CAP : in_req;
        w_need   = 3'((6'(w_target) - 6'(r_held) + 6'd7) >> 3);
        w_starve = (r_held < w_target) && (r_marker == MARK_NONE)
                   && (32'(r_level) < 32'(w_need));
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    case (in_kind)
                        KIND_READ, KIND_PEEK: begin
                            if (w_starve || (r_held >= w_target)) begin
                                n_state = ST_FINISH;
                            end else begin
                                n_state = ST_FETCH;
                            end
                        end
                        KIND_CONSUME, KIND_ALIGN: n_state = ST_FINISH;
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_FETCH: n_state = ST_MERGE;
            ST_MERGE: begin
                n_state = (w_held_add >= r_target) ? ST_FINISH : ST_FETCH;
            end
            ST_FINISH: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        n_buf       = r_buf;
        n_held      = r_held;
        n_pending   = r_pending;
        n_marker    = r_marker;
        n_rd_ptr    = r_rd_ptr;
        n_wr_ptr    = r_wr_ptr;
        n_level     = r_level;
        n_fault     = r_fault;
        n_kind      = r_kind;
        n_req       = r_req;
        n_target    = r_target;
        n_starve    = r_starve;
        n_from_ram  = r_from_ram;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_wdata   = in_byte;
        w_value     = '0;
        w_new_held  = r_held;

        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_kind   = in_kind;
                    n_req    = in_req;
                    n_target = w_target;
                    n_starve = 1'b0;
                    case (in_kind)
                        KIND_DATA: begin
                            if (r_marker == MARK_NONE) begin
                                if (r_pending) begin
                                    if (in_byte != BYTE_ESCAPE) begin
                                        n_pending = 1'b0;
                                        if (in_byte == BYTE_STUFF) begin
                                            ram_we    = 1'b1;
                                            ram_wdata = BYTE_ESCAPE;
                                        end else begin
                                            n_marker = in_byte;
                                        end
                                    end
                                end else if (in_byte == BYTE_ESCAPE) begin
                                    n_pending = 1'b1;
                                end else begin
                                    ram_we = 1'b1;
                                end
                            end
                            // A push into a full FIFO drops the byte.
                            if (ram_we && (r_level == LEVEL_FULL)) begin
                                ram_we = 1'b0;
                                if (r_fault == FAULT_NONE) begin
                                    n_fault = FAULT_OVERFLOW;
                                end
                            end
                            if (ram_we) begin
                                n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
                                n_level  = r_level + 1'b1;
                            end
                        end
                        KIND_END: begin
                            if (r_marker == MARK_NONE) begin
                                n_marker  = MARK_EOI;
                                n_pending = 1'b0;
                            end
                        end
                        KIND_READ, KIND_PEEK: n_starve = w_starve;
                        default: ;
                    endcase
                end
            end
            ST_FETCH: begin
                // Writes only happen in idle, so a read never meets a write in flight.
                if (r_level != '0) begin
                    ram_re     = 1'b1;
                    n_rd_ptr   = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
                    n_level    = r_level - 1'b1;
                    n_from_ram = 1'b1;
                end else begin
                    n_from_ram = 1'b0;
                end
            end
            ST_MERGE: begin
                n_buf  = {r_buf[23:0], (r_from_ram ? ram_rdata : BYTE_ESCAPE)};
                n_held = w_held_add;
            end
            ST_FINISH: begin
                if (w_out_free) begin
                    case (r_kind)
                        KIND_READ, KIND_PEEK: begin
                            if (!r_starve) begin
                                if (r_held < r_req) begin
                                    if ((r_kind == KIND_READ) && (r_fault == FAULT_NONE)) begin
                                        n_fault = FAULT_INVALID;
                                    end
                                end else begin
                                    w_value = (r_buf >> (r_held - r_req))
                                              & ((32'd1 << r_req) - 32'd1);
                                    if (r_kind == KIND_READ) begin
                                        w_new_held = r_held - r_req;
                                    end
                                end
                            end
                        end
                        KIND_CONSUME: begin
                            w_new_held = (r_req >= r_held) ? 5'd0 : r_held - r_req;
                        end
                        KIND_ALIGN: w_new_held = {r_held[4:3], 3'b000};
                        default: ;
                    endcase
                    n_held      = w_new_held;
                    n_buf       = r_buf & ((32'd1 << w_new_held) - 32'd1);
                    n_out_valid = 1'b1;
                    n_out_data  = {6'b0, r_marker, n_fault, r_starve, w_value[30:0]};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_buf       <= '0;
            r_held      <= '0;
            r_pending   <= 1'b0;
            r_marker    <= MARK_NONE;
            r_rd_ptr    <= '0;
            r_wr_ptr    <= '0;
            r_level     <= '0;
            r_fault     <= FAULT_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_buf       <= n_buf;
            r_held      <= n_held;
            r_pending   <= n_pending;
            r_marker    <= n_marker;
            r_rd_ptr    <= n_rd_ptr;
            r_wr_ptr    <= n_wr_ptr;
            r_level     <= n_level;
            r_fault     <= n_fault;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_req      <= n_req;
        r_target   <= n_target;
        r_starve   <= n_starve;
        r_from_ram <= n_from_ram;
        r_out_data <= n_out_data;
    end

    jebr_ram #(
        .WIDTH (8),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wr_ptr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_rd_ptr),
        .o_rdata (ram_rdata)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

>>> hdl/jebr_chk.sv
// Port-level checker of the bit reader, bound to the top level.
`include "jpeg_entropy_bit_reader_unit_assert.svh"

module jebr_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic [jebr_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    input logic [jebr_pkg::IN_USER_W-1:0]    s_axis_tuser,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [jebr_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
    import jebr_pkg::*;

    // A waiting result must neither vanish nor change.
    `JEBR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped or changed while stalled")

    // The sticky fault code only ever takes a defined value.
    `JEBR_ASSERT_NOW(a_fault_code, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[33:32] != 2'b11, "undefined fault code")

    // A starved request returns no bits.
    `JEBR_ASSERT_NOW(a_starved_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[31], m_axis_tdata[30:0] == 31'd0, "starved request returned bits")

    // After a data byte is accepted, the input side is ready again in the next cycle.
    `JEBR_ASSERT_NEXT(a_data_one_cycle, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_DATA), s_axis_tready, "data byte held the input side")

endmodule

bind jpeg_entropy_bit_reader_unit jebr_chk u_jebr_chk (.*);

>>> dv/jpeg_entropy_bit_reader_unit_tb.sv
// Self-checking testbench for the JPEG entropy-coded segment bit reader.
`timescale 1ns / 100ps

module jpeg_entropy_bit_reader_unit_tb;
    import jebr_pkg::*;

    localparam int FIFO_SLOTS  = 16;
    localparam int FILL_LIMIT  = 24;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HEAD_ROWS   = 24;
    localparam int SCRIPT_ROWS = 37;
    localparam int REPORT_MAX  = 10;

    // Kind codes outside the enum; the block drops them.
    localparam logic [2:0] KIND_SPARE_A = 3'd6;
    localparam logic [2:0] KIND_SPARE_B = 3'd7;

    typedef struct packed {
        logic [30:0] value;
        logic        starved;
        logic [1:0]  fault;
        logic [7:0]  marker;
    } t_reply;

    typedef struct {
        logic [2:0] kind;
        logic [7:0] dbyte;
        logic [4:0] nbits;
        int         reps;
        bit         typed;
        t_reply     want;
    } t_stim_row;

    localparam t_reply QUIET   = '{31'd0, 1'b0, FAULT_NONE, MARK_NONE};
    localparam t_reply STARVED = '{31'd0, 1'b1, FAULT_NONE, MARK_NONE};

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [7:0] data_byte, [12:8] bit_request, [15:13] zero
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // [2:0] kind
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [30:0] bits_value, [31] starved, [33:32] fault_code, [41:34] marker_seen,
    // [47:42] zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // Predicted reader state.
    logic [31:0]  buf_bits = '0;
    int unsigned  buf_count = 0;
    bit           esc_pending = 1'b0;
    logic [7:0]   marker_code = MARK_NONE;
    logic [7:0]   fifo_mem [FIFO_SLOTS];
    int unsigned  fifo_rd = 0;
    int unsigned  fifo_wr = 0;
    int unsigned  fifo_fill = 0;
    logic [1:0]   fault_state = FAULT_NONE;

    t_reply       request_replies [$];
    t_stim_row    script [SCRIPT_ROWS];
    int           mismatch_count = 0;
    int           cycle_count = 0;
    int           src_idle_pct = 0;
    int           sink_idle_pct = 0;
    logic         hold_trigger = 1'b0;
    logic         hold_started = 1'b0;
    int           hold_left = 0;

    jpeg_entropy_bit_reader_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [31:0] low_ones(int unsigned w);
        return (w >= 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 32'd1);
    endfunction

    function automatic void note_fault(logic [1:0] code);
        if (fault_state == FAULT_NONE) begin
            fault_state = code;
        end
    endfunction

    function automatic void queue_byte(logic [7:0] b);
        if (fifo_fill >= FIFO_SLOTS) begin
            note_fault(FAULT_OVERFLOW);
        end else begin
            fifo_mem[fifo_wr] = b;
            fifo_wr = (fifo_wr + 1) % FIFO_SLOTS;
            fifo_fill++;
        end
    endfunction

    function automatic void destuff_byte(logic [7:0] b);
        if (marker_code != MARK_NONE) begin
            return;
        end
        if (esc_pending) begin
            // Fill bytes after an escape are skipped; a stuffed zero is a data 0xFF.
            if (b == BYTE_ESCAPE) begin
                return;
            end
            esc_pending = 1'b0;
            if (b == BYTE_STUFF) begin
                queue_byte(BYTE_ESCAPE);
            end else begin
                marker_code = b;
            end
        end else if (b == BYTE_ESCAPE) begin
            esc_pending = 1'b1;
        end else begin
            queue_byte(b);
        end
    endfunction

    // Returns 0 when the FIFO cannot cover the fill and no marker allows padding.
    function automatic bit refill(int unsigned n);
        int unsigned goal;
        logic [7:0]  b;
        goal = (n > FILL_LIMIT) ? FILL_LIMIT : n;
        if (buf_count < goal && marker_code == MARK_NONE &&
            fifo_fill < (goal - buf_count + 7) / 8) begin
            return 1'b0;
        end
        while (buf_count < goal) begin
            if (fifo_fill > 0) begin
                b = fifo_mem[fifo_rd];
                fifo_rd = (fifo_rd + 1) % FIFO_SLOTS;
                fifo_fill--;
            end else begin
                b = 8'hFF;
            end
            buf_bits = {buf_bits[23:0], b};
            buf_count += 8;
        end
        buf_bits &= low_ones(buf_count);
        return 1'b1;
    endfunction

    function automatic void keep_bits(int unsigned count);
        buf_count = count;
        buf_bits &= low_ones(count);
    endfunction

    function automatic void advance_reader(logic [2:0] kind, logic [7:0] dbyte,
                                           logic [4:0] nbits);
        t_reply      r;
        int unsigned n;
        n = nbits;
        r = QUIET;
        case (kind)
            KIND_DATA: begin
                destuff_byte(dbyte);
            end
            KIND_END: begin
                if (marker_code == MARK_NONE) begin
                    marker_code = MARK_EOI;
                    esc_pending = 1'b0;
                end
            end
            KIND_READ, KIND_PEEK: begin
                if (!refill(n)) begin
                    r.starved = 1'b1;
                end else if (buf_count < n) begin
                    if (kind == KIND_READ) begin
                        note_fault(FAULT_INVALID);
                    end
                end else begin
                    r.value = 31'((buf_bits >> (buf_count - n)) & low_ones(n));
                    if (kind == KIND_READ) begin
                        keep_bits(buf_count - n);
                    end
                end
            end
            KIND_CONSUME: begin
                keep_bits((n >= buf_count) ? 0 : buf_count - n);
            end
            KIND_ALIGN: begin
                keep_bits((buf_count / 8) * 8);
            end
            default: ;
        endcase
        if (kind >= KIND_READ && kind <= KIND_ALIGN) begin
            r.fault = fault_state;
            r.marker = marker_code;
            request_replies.push_back(r);
        end
    endfunction

    // Offers one item, with random idle cycles in front, and predicts it once taken.
    task automatic send_item(input logic [2:0] kind, input logic [7:0] dbyte,
                             input logic [4:0] nbits);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {3'b000, nbits, dbyte};
        s_axis_tuser <= kind;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        advance_reader(kind, dbyte, nbits);
    endtask

    task automatic walk_script(input int first, input int stop);
        for (int i = first; i < stop; i++) begin
            for (int j = 0; j < script[i].reps; j++) begin
                send_item(script[i].kind, script[i].dbyte, script[i].nbits);
                if (script[i].typed) begin
                    request_replies[request_replies.size() - 1] = script[i].want;
                end
            end
        end
    endtask

    task automatic pick_item(input bit requests_only, output logic [2:0] kind,
                             output logic [7:0] dbyte, output logic [4:0] nbits);
        int roll;
        roll = requests_only ? $urandom_range(50, 99) : $urandom_range(0, 99);
        dbyte = 8'($urandom_range(0, 255));
        nbits = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(25, 31))
                                            : 5'($urandom_range(0, 24));
        if (roll < 4) begin
            kind = $urandom_range(0, 1) ? KIND_SPARE_A : KIND_SPARE_B;
        end else if (roll < 50) begin
            kind = KIND_DATA;
            // Keep the stream free of markers: an escape is always followed by
            // fill or a stuffed zero.
            if (esc_pending) begin
                dbyte = ($urandom_range(0, 3) == 0) ? BYTE_ESCAPE : BYTE_STUFF;
            end else if ($urandom_range(0, 9) == 0) begin
                dbyte = BYTE_ESCAPE;
            end
        end else if (roll < 72) begin
            kind = KIND_READ;
        end else if (roll < 84) begin
            kind = KIND_PEEK;
        end else if (roll < 94) begin
            kind = KIND_CONSUME;
        end else begin
            kind = KIND_ALIGN;
        end
    endtask

    task automatic run_random(input int count, input bit requests_only);
        int         taken;
        bit         dropped;
        logic [2:0] kind;
        logic [7:0] dbyte;
        logic [4:0] nbits;
        taken = 0;
        while (taken < count) begin
            pick_item(requests_only, kind, dbyte, nbits);
            dropped = (kind > KIND_ALIGN) ||
                      (kind <= KIND_END && marker_code != MARK_NONE);
            send_item(kind, dbyte, nbits);
            if (!dropped) begin
                taken++;
            end
        end
    endtask

    // Stop offering and wait for every outstanding result.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (request_replies.size() != 0);
    endtask

    always @(posedge i_clk) begin
        t_reply got;
        t_reply want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (hold_trigger && !hold_started) begin
                hold_started <= 1'b1;
                hold_left <= HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.value = m_axis_tdata[30:0];
                got.starved = m_axis_tdata[31];
                got.fault = m_axis_tdata[33:32];
                got.marker = m_axis_tdata[41:34];
                if (request_replies.size() == 0) begin
                    if (mismatch_count < REPORT_MAX) begin
                        $display("unexpected result: bits=%h starved=%0d fault=%0d marker=%h",
                                 got.value, got.starved, got.fault, got.marker);
                    end
                    mismatch_count++;
                end else begin
                    want = request_replies.pop_front();
                    if (got.value !== want.value || got.starved !== want.starved ||
                        got.fault !== want.fault || got.marker !== want.marker) begin
                        if (mismatch_count < REPORT_MAX) begin
                            $display("mismatch: expected bits=%h starved=%0d fault=%0d marker=%h",
                                     want.value, want.starved, want.fault, want.marker);
                            $display("          got      bits=%h starved=%0d fault=%0d marker=%h",
                                     got.value, got.starved, got.fault, got.marker);
                        end
                        mismatch_count++;
                    end
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin
        script = '{
            // Fresh after reset: nothing buffered, no fault, no marker.
            '{KIND_PEEK,    8'h00, 5'd0,  1,  1'b1, QUIET},
            '{KIND_READ,    8'h00, 5'd8,  1,  1'b1, STARVED},
            '{KIND_CONSUME, 8'h00, 5'd31, 1,  1'b1, QUIET},
            '{KIND_ALIGN,   8'h00, 5'd0,  1,  1'b1, QUIET},
            // Escape, fill byte, stuffed zero.
            '{KIND_DATA,    8'h00, 5'd0,  1,  1'b0, QUIET},
            '{KIND_DATA,    8'hFF, 5'd0,  1,  1'b0, QUIET},
            '{KIND_DATA,    8'hFF, 5'd0,  1,  1'b0, QUIET},
            '{KIND_DATA,    8'h00, 5'd0,  1,  1'b0, QUIET},
            '{KIND_DATA,    8'hA5, 5'd0,  1,  1'b0, QUIET},
            '{KIND_READ,    8'h00, 5'd4,  1,  1'b0, QUIET},
            '{KIND_PEEK,    8'h00, 5'd12, 1,  1'b0, QUIET},
            '{KIND_ALIGN,   8'h00, 5'd0,  1,  1'b0, QUIET},
            // Fills the FIFO and drops the last byte.
            '{KIND_DATA,    8'h5A, 5'd0,  16, 1'b0, QUIET},
            // Lacks bits after the fill; the overflow fault stays.
            '{KIND_READ,    8'h00, 5'd31, 1,  1'b0, QUIET},
            '{KIND_PEEK,    8'h00, 5'd24, 1,  1'b0, QUIET},
            '{KIND_READ,    8'h00, 5'd24, 1,  1'b0, QUIET},
            '{KIND_CONSUME, 8'h00, 5'd5,  1,  1'b0, QUIET},
            '{KIND_DATA,    8'hFF, 5'd0,  1,  1'b0, QUIET},
            '{KIND_READ,    8'h00, 5'd1,  1,  1'b0, QUIET},
            '{KIND_DATA,    8'h00, 5'd0,  1,  1'b0, QUIET},
            '{KIND_READ,    8'h00, 5'd17, 1,  1'b0, QUIET},
            '{KIND_SPARE_A, 8'hFF, 5'd31, 1,  1'b0, QUIET},
            '{KIND_SPARE_B, 8'h00, 5'd0,  1,  1'b0, QUIET},
            '{KIND_PEEK,    8'h00, 5'd31, 1,  1'b0, QUIET},
            // A marker stays until reset, so these rows run last.
            '{KIND_DATA,    8'hFF, 5'd0,  1,  1'b0, QUIET},
            '{KIND_DATA,    8'hFF, 5'd0,  1,  1'b0, QUIET},
            '{KIND_DATA,    8'hD0, 5'd0,  1,  1'b0, QUIET},
            '{KIND_DATA,    8'h00, 5'd0,  1,  1'b0, QUIET},
            '{KIND_DATA,    8'hFF, 5'd0,  1,  1'b0, QUIET},
            '{KIND_END,     8'h00, 5'd0,  1,  1'b0, QUIET},
            '{KIND_PEEK,    8'h00, 5'd24, 1,  1'b0, QUIET},
            '{KIND_READ,    8'h00, 5'd31, 1,  1'b0, QUIET},
            '{KIND_READ,    8'h00, 5'd24, 1,  1'b0, QUIET},
            '{KIND_CONSUME, 8'h00, 5'd3,  1,  1'b0, QUIET},
            '{KIND_ALIGN,   8'h00, 5'd0,  1,  1'b0, QUIET},
            '{KIND_READ,    8'h00, 5'd0,  1,  1'b0, QUIET},
            '{KIND_PEEK,    8'h00, 5'd31, 1,  1'b0, QUIET}
        };
        // Half the seeds latch the end marker over a pending escape instead.
        if ($urandom_range(0, 1) == 1) begin
            script[HEAD_ROWS + 2].kind = KIND_END;
        end

        src_idle_pct = 29;
        sink_idle_pct = 85;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        walk_script(0, HEAD_ROWS);
        run_random(260, 1'b0);
        settle();

        src_idle_pct = 85;
        sink_idle_pct = 29;
        run_random(260, 1'b0);
        settle();

        // The receiver stalls for a long stretch while requests keep coming.
        src_idle_pct = 0;
        sink_idle_pct = 0;
        hold_trigger <= 1'b1;
        run_random(260, 1'b0);
        walk_script(HEAD_ROWS, SCRIPT_ROWS);
        run_random(40, 1'b1);
        settle();
        repeat (20) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
